/* rtl/core/json_document_framer_macros.svh */
// Assertion macros used by the checker file of the JSON document framer.
`ifndef JSON_DOCUMENT_FRAMER_MACROS_SVH
`define JSON_DOCUMENT_FRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JDF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer assertion failed");

// Next-cycle implication, disabled during reset.
`define JDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framer assertion failed");

`endif

/* rtl/core/jdf_pkg.sv */
// Package with byte codes, framer mode codes and payload types of the JSON framer.
package jdf_pkg;

   localparam int unsigned JDF_MAX_DEPTH = 255;

   localparam logic [7:0] ByteOpenBrace   = 8'h7B;
   localparam logic [7:0] ByteOpenBrack   = 8'h5B;
   localparam logic [7:0] ByteCloseBrace  = 8'h7D;
   localparam logic [7:0] ByteCloseBrack  = 8'h5D;
   localparam logic [7:0] ByteBackslash   = 8'h5C;
   localparam logic [7:0] ByteQuote       = 8'h22;
   localparam logic [7:0] ByteNewline     = 8'h0A;
   localparam logic [7:0] ByteSpace       = 8'h20;
   localparam logic [7:0] ByteTab         = 8'h09;
   localparam logic [7:0] ByteReturn      = 8'h0D;

   localparam logic [1:0] ModeIdle = 2'd0;
   localparam logic [1:0] ModeJunk = 2'd1;
   localparam logic [1:0] ModeDoc  = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
   } jdf_req_type;

   typedef struct packed {
      logic in_document;
      logic doc_start;
      logic doc_end;
      logic nest_overflow;
   } jdf_flags_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       in_document;
      logic       doc_start;
      logic       doc_end;
      logic       nest_overflow;
   } jdf_rsp_type;

endpackage

/* rtl/core/jdf_stream_if.sv */
// Valid/ready stream interface with a typed payload.
interface jdf_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/jdf_step.sv */
// Next-state and flag logic of the framer for one byte.
module jdf_step #(
   parameter int unsigned MAX_DEPTH = jdf_pkg::JDF_MAX_DEPTH,
   parameter int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1)
) (
   input  logic [7:0]            data_byte,
   input  logic [1:0]            mode_cur,
   input  logic [DEPTH_W-1:0]    depth_cur,
   input  logic                  str_cur,
   input  logic                  esc_cur,
   output logic [1:0]            mode_nxt,
   output logic [DEPTH_W-1:0]    depth_nxt,
   output logic                  str_nxt,
   output logic                  esc_nxt,
   output jdf_pkg::jdf_flags_type flags
);
   import jdf_pkg::*;

   localparam logic [DEPTH_W-1:0] DepthMax = DEPTH_W'(MAX_DEPTH);
   localparam logic [DEPTH_W-1:0] DepthOne = DEPTH_W'(1);

   logic                is_open;
   logic                is_close;
   logic                is_space;
   logic [DEPTH_W-1:0]  depth_dec;

   assign is_open  = (data_byte == ByteOpenBrace) || (data_byte == ByteOpenBrack);
   assign is_close = (data_byte == ByteCloseBrace) || (data_byte == ByteCloseBrack);
   assign is_space = (data_byte == ByteSpace) || (data_byte == ByteTab) ||
                     (data_byte == ByteReturn) || (data_byte == ByteNewline);
   assign depth_dec = (depth_cur != '0) ? depth_cur - DepthOne : depth_cur;

   always_comb begin
      mode_nxt  = mode_cur;
      depth_nxt = depth_cur;
      str_nxt   = str_cur;
      esc_nxt   = esc_cur;
      flags     = '0;
      unique case (mode_cur)
         ModeDoc: begin
            flags.in_document = 1'b1;
            if (str_cur) begin
               if (esc_cur) begin
                  esc_nxt = 1'b0;
               end else if (data_byte == ByteBackslash) begin
                  esc_nxt = 1'b1;
               end else if (data_byte == ByteQuote) begin
                  str_nxt = 1'b0;
               end
            end else if (data_byte == ByteQuote) begin
               str_nxt = 1'b1;
            end else if (is_open) begin
               if (depth_cur >= DepthMax) begin
                  depth_nxt           = DepthMax;
                  flags.nest_overflow = 1'b1;
               end else begin
                  depth_nxt = depth_cur + DepthOne;
               end
            end else if (is_close) begin
               depth_nxt = depth_dec;
               if (depth_dec == '0) begin
                  flags.doc_end = 1'b1;
                  mode_nxt      = ModeIdle;
                  str_nxt       = 1'b0;
                  esc_nxt       = 1'b0;
               end
            end
         end
         ModeJunk: begin
            if (data_byte == ByteNewline) begin
               mode_nxt = ModeIdle;
            end
         end
         default: begin
            // Idle; the unused mode code behaves the same way.
            mode_nxt = ModeIdle;
            if (is_space) begin
               mode_nxt = ModeIdle;
            end else if (is_open) begin
               mode_nxt          = ModeDoc;
               depth_nxt         = DepthOne;
               str_nxt           = 1'b0;
               esc_nxt           = 1'b0;
               flags.in_document = 1'b1;
               flags.doc_start   = 1'b1;
            end else begin
               mode_nxt = ModeJunk;
            end
         end
      endcase
   end

endmodule

/* rtl/core/json_document_framer.sv */
// An accepted request byte waits in the input register; its result is then offered from
// the result register. One byte per clock unless rsp_if stalls; state advances once per byte.
// A two-stage pipeline (input register, result register) lets a new request in while a
// finished result still waits downstream.
// Reset (synchronous, active high) empties both stages and returns the framer to idle
// with zero depth, outside any string and with no escape pending.
module json_document_framer #(
   parameter int unsigned MAX_DEPTH = jdf_pkg::JDF_MAX_DEPTH
) (
   input logic          clock,
   input logic          reset,
   jdf_stream_if.sink   req_if,
   jdf_stream_if.source rsp_if
);
   import jdf_pkg::*;

   // The depth counter only needs to reach MAX_DEPTH, since it saturates there.
   localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);

   // Input stage: holds one accepted request byte.
   logic              s1_valid_ff, s1_valid_in;
   logic [7:0]        s1_byte_ff, s1_byte_in;

   // Result stage: holds one finished result until the sink takes it.
   logic              s2_valid_ff, s2_valid_in;
   jdf_rsp_type       s2_rsp_ff, s2_rsp_in;

   // Framing state, advanced once per byte as it moves from stage one to stage two.
   logic [1:0]        mode_ff, mode_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic              str_ff, str_in;
   logic              esc_ff, esc_in;

   logic              s2_ready;
   logic              s1_ready;
   logic              advance;
   logic              req_take;
   logic [1:0]        mode_nxt;
   logic [DEPTH_W-1:0] depth_nxt;
   logic              str_nxt;
   logic              esc_nxt;
   jdf_flags_type     flags;

   // Stage two can take a new result when empty or when its result leaves this cycle.
   // Stage one likewise frees up when its byte moves forward.
   assign s2_ready = !s2_valid_ff || rsp_if.ready;
   assign advance  = s1_valid_ff && s2_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_take = req_if.valid && s1_ready;

   assign req_if.ready   = s1_ready;
   assign rsp_if.valid   = s2_valid_ff;
   assign rsp_if.payload = s2_rsp_ff;

   jdf_step #(
      .MAX_DEPTH (MAX_DEPTH),
      .DEPTH_W   (DEPTH_W)
   ) u_step (
      .data_byte (s1_byte_ff),
      .mode_cur  (mode_ff),
      .depth_cur (depth_ff),
      .str_cur   (str_ff),
      .esc_cur   (esc_ff),
      .mode_nxt  (mode_nxt),
      .depth_nxt (depth_nxt),
      .str_nxt   (str_nxt),
      .esc_nxt   (esc_nxt),
      .flags     (flags)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s2_valid_in = s2_valid_ff;
      s2_rsp_in   = s2_rsp_ff;
      mode_in     = mode_ff;
      depth_in    = depth_ff;
      str_in      = str_ff;
      esc_in      = esc_ff;

      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
      end
      if (advance) begin
         s2_rsp_in.out_byte      = s1_byte_ff;
         s2_rsp_in.in_document   = flags.in_document;
         s2_rsp_in.doc_start     = flags.doc_start;
         s2_rsp_in.doc_end       = flags.doc_end;
         s2_rsp_in.nest_overflow = flags.nest_overflow;
         mode_in  = mode_nxt;
         depth_in = depth_nxt;
         str_in   = str_nxt;
         esc_in   = esc_nxt;
      end
      if (s1_ready) begin
         s1_valid_in = req_if.valid;
      end
      if (req_take) begin
         s1_byte_in = req_if.payload.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         mode_ff     <= ModeIdle;
         depth_ff    <= '0;
         str_ff      <= 1'b0;
         esc_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         mode_ff     <= mode_in;
         depth_ff    <= depth_in;
         str_ff      <= str_in;
         esc_ff      <= esc_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      s2_rsp_ff  <= s2_rsp_in;
   end

endmodule

/* rtl/core/jdf_checker.sv */
// Port-level checker for the JSON document framer and its bind statement.
`include "json_document_framer_macros.svh"

module jdf_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input jdf_pkg::jdf_rsp_type rsp_payload
);
   import jdf_pkg::*;

   logic open_byte;

   assign open_byte = (rsp_payload.out_byte == ByteOpenBrace) ||
                      (rsp_payload.out_byte == ByteOpenBrack);

   // A document starts only on an opening bracket, which is part of the document.
   `JDF_ASSERT_IMPL(a_start_on_open, clock, reset, rsp_valid && rsp_payload.doc_start, open_byte && rsp_payload.in_document)

   // A document ends inside the document, on a byte that does not also open one.
   `JDF_ASSERT_IMPL(a_end_in_doc, clock, reset, rsp_valid && rsp_payload.doc_end, rsp_payload.in_document && !rsp_payload.doc_start)

   // Overflow is reported only for an opening bracket inside a running document.
   `JDF_ASSERT_IMPL(a_ovf_open, clock, reset, rsp_valid && rsp_payload.nest_overflow, open_byte && rsp_payload.in_document && !rsp_payload.doc_start)

   // A result that is not taken stays on the channel unchanged.
   `JDF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind json_document_framer jdf_checker u_jdf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
